### sv/bls_pkg.sv
// Package: shared constants, types and the control-store program of the line stepper.
package bls_pkg;

    // Coordinate width; the tile is 2**COORD_BITS pixels square.
    localparam int COORD_BITS  = 6;
    localparam int COLOUR_BITS = 24;
    // Error term width: holds sums of a few doubled coordinate deltas.
    localparam int D_BITS      = COORD_BITS + 4;
    localparam int PC_BITS     = 2;

    typedef logic        [COORD_BITS-1:0]  t_coord;
    typedef logic signed [COORD_BITS:0]    t_delta;
    typedef logic signed [D_BITS-1:0]      t_err;
    typedef logic        [COLOUR_BITS-1:0] t_colour;
    typedef logic        [PC_BITS-1:0]     t_pc;

    // Datapath operations.
    localparam logic [1:0] OP_NOP   = 2'd0;
    localparam logic [1:0] OP_LOAD  = 2'd1;
    localparam logic [1:0] OP_SETUP = 2'd2;
    localparam logic [1:0] OP_STEP  = 2'd3;

    // Jump conditions.
    localparam logic [1:0] COND_NEXT   = 2'd0;  // fall through to pc + 1
    localparam logic [1:0] COND_ALWAYS = 2'd1;
    localparam logic [1:0] COND_MORE   = 2'd2;  // jump while pixels remain

    // Octant cases.
    localparam logic [1:0] MODE_STEEP_UP     = 2'd0;
    localparam logic [1:0] MODE_SHALLOW_UP   = 2'd1;
    localparam logic [1:0] MODE_SHALLOW_DOWN = 2'd2;
    localparam logic [1:0] MODE_STEEP_DOWN   = 2'd3;

    // Program addresses.
    localparam t_pc PC_FETCH = 2'd0;
    localparam t_pc PC_SETUP = 2'd1;
    localparam t_pc PC_EMIT  = 2'd2;
    localparam t_pc PC_DONE  = 2'd3;

    typedef struct packed {
        logic       take;    // ready on the request channel
        logic       emit;    // valid on the pixel channel
        logic [1:0] op;
        logic [1:0] cond;
        t_pc        target;
    } t_uword;

    // Control to the datapath.
    typedef struct packed {
        logic [1:0] op;
        logic       adv;     // the current word completes this cycle
    } t_ctrl;

    // Status back to the sequencer.
    typedef struct packed {
        logic in_valid;
        logic out_ready;
        logic last;
    } t_stat;

    function automatic t_uword rom_word(input t_pc pc);
        t_uword w;
        w = '0;
        unique case (pc)
            PC_FETCH: begin
                w.take = 1'b1; w.op = OP_LOAD;  w.cond = COND_NEXT;   w.target = PC_FETCH;
            end
            PC_SETUP: begin
                w.op = OP_SETUP; w.cond = COND_NEXT;   w.target = PC_FETCH;
            end
            PC_EMIT: begin
                w.emit = 1'b1; w.op = OP_STEP; w.cond = COND_MORE; w.target = PC_EMIT;
            end
            PC_DONE: begin
                w.op = OP_NOP;   w.cond = COND_ALWAYS; w.target = PC_FETCH;
            end
            default: w = '0;
        endcase
        return w;
    endfunction

endpackage

### sv/bls_ifs.sv
// Interfaces: line request channel and pixel channel.
interface bls_req_if;
    logic               valid;
    logic               ready;
    bls_pkg::t_coord    start_x;
    bls_pkg::t_coord    start_y;
    bls_pkg::t_coord    end_x;
    bls_pkg::t_coord    end_y;
    bls_pkg::t_colour   pixel_colour;

    modport source (output valid, start_x, start_y, end_x, end_y, pixel_colour,
                    input ready);
    modport sink   (input valid, start_x, start_y, end_x, end_y, pixel_colour,
                    output ready);
endinterface

interface bls_pix_if;
    logic               valid;
    logic               ready;
    bls_pkg::t_coord    pixel_x;
    bls_pkg::t_coord    pixel_y;
    bls_pkg::t_colour   out_colour;
    logic               last_pixel;

    modport source (output valid, pixel_x, pixel_y, out_colour, last_pixel,
                    input ready);
    modport sink   (input valid, pixel_x, pixel_y, out_colour, last_pixel,
                    output ready);
endinterface

### sv/bls_useq.sv
// Microsequencer: program counter, control store and jump logic.
module bls_useq (
    input  logic             i_clk,
    input  logic             i_rst_n,
    input  bls_pkg::t_stat   i_stat,
    output bls_pkg::t_uword  o_word,
    output bls_pkg::t_ctrl   o_ctrl
);

    bls_pkg::t_pc    r_pc;
    bls_pkg::t_pc    n_pc;
    bls_pkg::t_uword w;
    logic            stall;
    logic            jump;

    assign w = bls_pkg::rom_word(r_pc);

    always_comb begin
        stall = (w.take && !i_stat.in_valid) || (w.emit && !i_stat.out_ready);
        unique case (w.cond)
            bls_pkg::COND_ALWAYS: jump = 1'b1;
            bls_pkg::COND_MORE:   jump = !i_stat.last;
            default:              jump = 1'b0;
        endcase
        if (stall) begin
            n_pc = r_pc;
        end else if (jump) begin
            n_pc = w.target;
        end else begin
            n_pc = r_pc + bls_pkg::t_pc'(1);
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_pc <= bls_pkg::PC_FETCH;
        end else begin
            r_pc <= n_pc;
        end
    end

    assign o_word     = w;
    assign o_ctrl.op  = w.op;
    assign o_ctrl.adv = !stall;

endmodule

### sv/bls_datapath.sv
// Datapath: endpoint swap, octant setup, error term and pixel counters.
module bls_datapath (
    input  logic               i_clk,
    input  bls_pkg::t_ctrl     i_ctrl,
    input  bls_pkg::t_coord    i_x0,
    input  bls_pkg::t_coord    i_y0,
    input  bls_pkg::t_coord    i_x1,
    input  bls_pkg::t_coord    i_y1,
    input  bls_pkg::t_colour   i_colour,
    output bls_pkg::t_coord    o_x,
    output bls_pkg::t_coord    o_y,
    output bls_pkg::t_colour   o_colour,
    output logic               o_last
);

    localparam int CB = bls_pkg::COORD_BITS;

    bls_pkg::t_coord  r_x, r_y, r_dx, r_cnt;
    bls_pkg::t_delta  r_a;
    bls_pkg::t_err    r_d, r_inc_minor, r_inc_major;
    bls_pkg::t_colour r_colour;
    logic [1:0]       r_mode;

    bls_pkg::t_coord  lx0, ly0, lx1, ly1;
    bls_pkg::t_err    a_d, dx_d, na_d;
    logic             neg, pos, take_minor, x_major, y_up, step_x, step_y;

    // Swap so x never decreases.
    always_comb begin
        if (i_x0 > i_x1) begin
            lx0 = i_x1; ly0 = i_y1; lx1 = i_x0; ly1 = i_y0;
        end else begin
            lx0 = i_x0; ly0 = i_y0; lx1 = i_x1; ly1 = i_y1;
        end
    end

    always_comb begin
        a_d  = bls_pkg::t_err'(r_a);
        dx_d = bls_pkg::t_err'({1'b0, r_dx});
        na_d = -a_d;
        neg  = r_d[bls_pkg::D_BITS-1];
        pos  = !neg && (r_d != '0);
        take_minor = (r_mode == bls_pkg::MODE_STEEP_UP) ? neg : pos;
        x_major = (r_mode == bls_pkg::MODE_SHALLOW_UP) ||
                  (r_mode == bls_pkg::MODE_SHALLOW_DOWN);
        y_up    = (r_mode == bls_pkg::MODE_STEEP_UP) ||
                  (r_mode == bls_pkg::MODE_SHALLOW_UP);
        step_x  = x_major || take_minor;
        step_y  = !x_major || take_minor;
    end

    always_ff @(posedge i_clk) begin
        if (i_ctrl.adv) begin
            case (i_ctrl.op)
                bls_pkg::OP_LOAD: begin
                    r_x      <= lx0;
                    r_y      <= ly0;
                    r_dx     <= lx1 - lx0;
                    r_a      <= bls_pkg::t_delta'({1'b0, ly1}) -
                                bls_pkg::t_delta'({1'b0, ly0});
                    r_colour <= i_colour;
                end
                bls_pkg::OP_SETUP: begin
                    if (a_d > dx_d) begin
                        r_mode      <= bls_pkg::MODE_STEEP_UP;
                        r_d         <= a_d - (dx_d <<< 1);
                        r_inc_minor <= a_d <<< 1;
                        r_inc_major <= -(dx_d <<< 1);
                        r_cnt       <= r_a[CB-1:0];
                    end else if (a_d > bls_pkg::t_err'(0)) begin
                        r_mode      <= bls_pkg::MODE_SHALLOW_UP;
                        r_d         <= (a_d <<< 1) - dx_d;
                        r_inc_minor <= -(dx_d <<< 1);
                        r_inc_major <= a_d <<< 1;
                        r_cnt       <= r_dx;
                    end else if (na_d < dx_d) begin
                        r_mode      <= bls_pkg::MODE_SHALLOW_DOWN;
                        r_d         <= (na_d <<< 1) - dx_d;
                        r_inc_minor <= -(dx_d <<< 1);
                        r_inc_major <= na_d <<< 1;
                        r_cnt       <= r_dx;
                    end else begin
                        r_mode      <= bls_pkg::MODE_STEEP_DOWN;
                        r_d         <= a_d + (dx_d <<< 1);
                        r_inc_minor <= a_d <<< 1;
                        r_inc_major <= dx_d <<< 1;
                        r_cnt       <= na_d[CB-1:0];
                    end
                end
                bls_pkg::OP_STEP: begin
                    r_d <= r_d + (take_minor ? r_inc_minor : '0) + r_inc_major;
                    if (step_x) begin
                        r_x <= r_x + bls_pkg::t_coord'(1);
                    end
                    if (step_y) begin
                        r_y <= y_up ? r_y + bls_pkg::t_coord'(1)
                                    : r_y - bls_pkg::t_coord'(1);
                    end
                    r_cnt <= r_cnt - bls_pkg::t_coord'(1);
                end
                default: ;
            endcase
        end
    end

    assign o_x      = r_x;
    assign o_y      = r_y;
    assign o_colour = r_colour;
    assign o_last   = (r_cnt == '0);

endmodule

### sv/bresenham_line_stepper.sv
// Top level of the line stepper: sequencer plus datapath behind two valid/ready channels.
// Usage:
//   i_req carries one line request per beat: start_x/start_y, end_x/end_y and a
//   24-bit colour. o_pix carries one pixel per beat, in drawing order, with
//   last_pixel set on the final pixel of the line.
//   A line of N pixels (N = max(|dx|, |dy|) + 1, at most 64) gives its first
//   pixel from the emit word, after the fetch word takes the request beat and
//   the setup word runs; then one pixel per cycle while the receiver is ready.
//   The request channel is ready again once the done word has run after the
//   last pixel beat. The steps come from the four-word control program: fetch,
//   setup, emit loop (one pixel per pass), done.
//   Reset parks the program counter at the fetch word and holds both handshake
//   lines low; nothing else needs clearing since each request stands alone.
//   When the receiver holds ready low the emit word stalls: the pixel and all
//   datapath state hold until the beat completes. Requests are not taken
//   while a line is in progress.
module bresenham_line_stepper (
    input  logic        i_clk,
    input  logic        i_rst_n,
    bls_req_if.sink     i_req,
    bls_pix_if.source   o_pix
);

    bls_pkg::t_uword w;
    bls_pkg::t_ctrl  ctrl;
    bls_pkg::t_stat  stat;
    logic            last;

    // Handshake status fed back into the stall logic, last-pixel status into the jump logic.
    assign stat.in_valid  = i_req.valid;
    assign stat.out_ready = o_pix.ready;
    assign stat.last      = last;

    bls_useq u_useq (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_stat  (stat),
        .o_word  (w),
        .o_ctrl  (ctrl)
    );

    bls_datapath u_dp (
        .i_clk    (i_clk),
        .i_ctrl   (ctrl),
        .i_x0     (i_req.start_x),
        .i_y0     (i_req.start_y),
        .i_x1     (i_req.end_x),
        .i_y1     (i_req.end_y),
        .i_colour (i_req.pixel_colour),
        .o_x      (o_pix.pixel_x),
        .o_y      (o_pix.pixel_y),
        .o_colour (o_pix.out_colour),
        .o_last   (last)
    );

    // Handshake lines come straight from the current control word; no beat in reset.
    assign i_req.ready      = w.take && i_rst_n;
    assign o_pix.valid      = w.emit && i_rst_n;
    assign o_pix.last_pixel = last;

endmodule
